// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Each check is clocked on the rising edge and held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OPW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define OPW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (!(cond))) else $error(msg);

`else

`define OPW_ASSERT(label, clk, rst_n, prop, msg)

`define OPW_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/opw_pkg.sv =====
`timescale 1ns / 1ps

package opw_pkg;

	localparam int MAG_W       = 24;
	localparam int NOM_W       = 16;
	localparam int SYNC_W      = 23;
	localparam int TOL_W       = 7;
	localparam int MARGIN_W    = 17;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 23;
	localparam int PROD_W      = NOM_W + RECIP_W;
	localparam int COUNT_W     = 16;
	localparam int ITEMS_W     = 3;
	localparam int OUT_VALUE_W = 64;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 23;
	localparam int TOL_DEPTH   = 1 << TOL_W;

	localparam logic [ITEMS_W-1:0] ITEMS_MIN = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 8'd3;

	localparam logic [NOM_W-1:0]  SHORT_RESET = 16'd350;
	localparam logic [NOM_W-1:0]  LONG_RESET  = 16'd1050;
	localparam logic [SYNC_W-1:0] SYNC_RESET  = 23'd4000;
	localparam logic [TOL_W-1:0]  TOL_RESET   = 7'd25;

	typedef enum logic [1:0] {
		PH_SYNC  = 2'd0,
		PH_MARK  = 2'd1,
		PH_SPACE = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] duration;
		logic                    last_item;
	} in_word_t;

	typedef struct packed {
		logic                   found;
		logic [COUNT_W-1:0]     bit_count;
		logic [OUT_VALUE_W-1:0] value;
	} out_word_t;

	// ceil(t * 2^23 / 100): n * entry >> 23 equals floor(n * t / 100) for any 16-bit n
	typedef logic [TOL_DEPTH-1:0][RECIP_W-1:0] recip_tab_t;

	function automatic recip_tab_t build_recip();
		recip_tab_t tab;
		for (int i = 0; i < TOL_DEPTH; i++) begin
			tab[i] = RECIP_W'(((longint'(i) <<< RECIP_SHIFT) + 64'd99) / 64'd100);
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ===== rtl/ook_pulse_width_decoder.sv =====
`timescale 1ns / 1ps
// OOK pulse-width decoder.
// Input channel (in_valid/in_ready/in_data): one signed pulse duration per word,
// with last_item set on the final duration of a capture. Only the magnitude counts.
// Output channel (out_valid/out_ready/out_data): one word per capture, issued for
// the word flagged last_item: found, saturating bit_count and the decoded value.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle writes, no read-back;
// unknown indexes are dropped. Input is held off during a write cycle.
// A last_item word is decoded from the input register straight into the result
// register, and waits in the input register while the output word is stalled.
// Throughput: one word per cycle while no config write holds the input off and no
// last_item word waits on a stalled output; decode state is updated as each word
// leaves the input register. Tolerance margins are re-derived from the registers
// every cycle through one multiplier per nominal, so they follow a register write
// in the cycle after it. A stalled output word blocks only a last_item word behind
// it; other durations keep flowing.
// Reset: registers return to 350/1050/4000/25, the capture state clears and
// both channels come up empty.

`include "assert_macros.svh"

module ook_pulse_width_decoder import opw_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [NOM_W-1:0]  short_q;
	logic [NOM_W-1:0]  long_q;
	logic [SYNC_W-1:0] sync_q;
	logic [TOL_W-1:0]  tol_q;

	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   short_prod;
	logic [PROD_W-1:0]   long_prod;
	logic [MARGIN_W-1:0] short_margin_q;
	logic [MARGIN_W-1:0] long_margin_q;

	// input stage
	logic             valid_s1;
	logic             last_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [MAG_W-1:0] raw;
	logic [MAG_W-1:0] mag_in;
	logic             s1_go;
	logic             out_free;

	// capture state
	phase_t                phase_q, phase_n;
	logic [MAG_W-1:0]      held_q, held_n;
	logic [VALUE_BITS-1:0] shift_q, shift_n;
	logic [COUNT_W-1:0]    bits_seen_q, bits_n;
	logic [ITEMS_W-1:0]    items_q, items_n;

	logic hs_hit, hl_hit, ms_hit, ml_hit;
	logic zero_pair, one_pair, push;
	logic found_n;
	out_word_t result;

	// result register
	logic      out_valid_q;
	out_word_t out_data_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= SHORT_RESET;
			long_q  <= LONG_RESET;
			sync_q  <= SYNC_RESET;
			tol_q   <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_PULSE: short_q <= cfg_data[NOM_W-1:0];
				REG_LONG_PULSE:  long_q  <= cfg_data[NOM_W-1:0];
				REG_SYNC_MIN:    sync_q  <= cfg_data[SYNC_W-1:0];
				REG_TOLERANCE:   tol_q   <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// margin = floor(nominal * tol / 100), refreshed every cycle
	assign recip      = RECIP_TAB[tol_q];
	assign short_prod = PROD_W'(short_q) * PROD_W'(recip);
	assign long_prod  = PROD_W'(long_q) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		short_margin_q <= short_prod[RECIP_SHIFT +: MARGIN_W];
		long_margin_q  <= long_prod[RECIP_SHIFT +: MARGIN_W];
	end

	// handshake
	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !cfg_we && (!valid_s1 || s1_go);

	// two's complement magnitude; the most negative code maps to 2^23 unchanged
	assign raw    = in_data.duration;
	assign mag_in = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;

	// a word decoded while a write holds the input off leaves the stage empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mag_s1  <= mag_in;
			last_s1 <= in_data.last_item;
		end
	end

	opw_window u_held_short (
		.mag     (held_q),
		.nominal (short_q),
		.margin  (short_margin_q),
		.hit     (hs_hit)
	);

	opw_window u_held_long (
		.mag     (held_q),
		.nominal (long_q),
		.margin  (long_margin_q),
		.hit     (hl_hit)
	);

	opw_window u_mag_short (
		.mag     (mag_s1),
		.nominal (short_q),
		.margin  (short_margin_q),
		.hit     (ms_hit)
	);

	opw_window u_mag_long (
		.mag     (mag_s1),
		.nominal (long_q),
		.margin  (long_margin_q),
		.hit     (ml_hit)
	);

	assign zero_pair = hs_hit && ml_hit;
	assign one_pair  = hl_hit && ms_hit;

	// next phase
	always_comb begin
		phase_n = phase_q;
		case (phase_q)
			PH_SYNC: begin
				if (mag_s1 >= MAG_W'(sync_q)) begin
					phase_n = PH_MARK;
				end
			end
			PH_MARK:  phase_n = PH_SPACE;
			PH_SPACE: phase_n = (zero_pair || one_pair) ? PH_MARK : PH_STOP;
			PH_STOP:  phase_n = PH_STOP;
			default:  phase_n = PH_SYNC;
		endcase
	end

	// datapath updates and result word
	always_comb begin
		push    = (phase_q == PH_SPACE) && (zero_pair || one_pair);
		held_n  = (phase_q == PH_MARK) ? mag_s1 : held_q;
		shift_n = push ? {shift_q[VALUE_BITS-2:0], !zero_pair} : shift_q;
		bits_n  = (push && (bits_seen_q != '1)) ? (bits_seen_q + COUNT_W'(1)) : bits_seen_q;
		items_n = (items_q < ITEMS_MIN) ? (items_q + ITEMS_W'(1)) : items_q;
		found_n = (items_n >= ITEMS_MIN) && (bits_n != '0);

		result.found     = found_n;
		result.bit_count = found_n ? bits_n : '0;
		result.value     = found_n ? OUT_VALUE_W'(shift_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC;
			held_q      <= '0;
			shift_q     <= '0;
			bits_seen_q <= '0;
			items_q     <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				phase_q     <= PH_SYNC;
				held_q      <= '0;
				shift_q     <= '0;
				bits_seen_q <= '0;
				items_q     <= '0;
			end else begin
				phase_q     <= phase_n;
				held_q      <= held_n;
				shift_q     <= shift_n;
				bits_seen_q <= bits_n;
				items_q     <= items_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`OPW_ASSERT(a_bits_after_sync, clk, arst_n,
		(bits_seen_q != '0) |-> (phase_q != PH_SYNC), "bits counted without sync")
	`OPW_ASSERT_NEVER(a_items_sat, clk, arst_n, items_q > ITEMS_MIN, "item count past saturation")
	`OPW_ASSERT(a_found_has_bits, clk, arst_n,
		(out_valid_q && out_data_q.found) |-> (out_data_q.bit_count != '0),
		"found word with no bits")
	`OPW_ASSERT(a_miss_is_zero, clk, arst_n,
		(out_valid_q && !out_data_q.found) |->
			((out_data_q.bit_count == '0) && (out_data_q.value == '0)),
		"miss word not cleared")
	`OPW_ASSERT(a_last_gives_word, clk, arst_n,
		(s1_go && last_s1) |=> out_valid_q, "last duration gave no word")

endmodule

// ===== rtl/opw_window.sv =====
`timescale 1ns / 1ps

module opw_window import opw_pkg::*; (
	input  logic [MAG_W-1:0]    mag,
	input  logic [NOM_W-1:0]    nominal,
	input  logic [MARGIN_W-1:0] margin,
	output logic                hit
);

	logic [MAG_W-1:0] nom_ext;
	logic [MAG_W-1:0] diff;

	assign nom_ext = MAG_W'(nominal);
	assign diff    = (mag >= nom_ext) ? (mag - nom_ext) : (nom_ext - mag);
	assign hit     = (diff <= MAG_W'(margin));

endmodule
